FILE: design/crc16fpr_pkg.sv
// ----------------------------------------------------------------------------
// crc16fpr_pkg
// Types, constants and the CRC-16/Modbus byte update for the framed packet
// receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc16fpr_pkg;

    localparam logic [7:0]  HDR_FIRST      = 8'hA5;
    localparam logic [7:0]  HDR_SECOND     = 8'h5A;
    localparam logic [7:0]  TAIL_BYTE      = 8'hFF;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  DECODE_CMD_RST = 8'h02;

    localparam int STORE_DEPTH = 22;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        ST_WAIT_A5,
        ST_WAIT_5A,
        ST_LENGTH,
        ST_COMMAND,
        ST_PAYLOAD,
        ST_CRC_HI,
        ST_CRC_LO,
        ST_TAIL
    } t_parse_state;

    typedef enum logic [2:0] {
        FS_DECODED   = 3'd0,
        FS_OTHER_CMD = 3'd1,
        FS_SHORT     = 3'd2,
        FS_CRC_ERR   = 3'd3,
        FS_BAD_TAIL  = 3'd4
    } t_frame_status;

    typedef struct packed {
        logic [15:0]   action_word;
        logic [31:0]   distance_bits;
        logic [31:0]   roll_bits;
        logic [31:0]   pitch_bits;
        logic [31:0]   yaw_bits;
        logic [31:0]   speed_bits;
        logic [7:0]    payload_length;
        logic [7:0]    frame_command;
        t_frame_status frame_status;
    } t_result;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

FILE: design/crc16fpr_parser.sv
// ----------------------------------------------------------------------------
// crc16fpr_parser
// Frame hunt state machine with running CRC, payload field store and result
// formation for one registered byte per cycle while i_step is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc16fpr_parser
    import crc16fpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_decode_command,
    output logic        o_emit,
    output t_result     o_result
);

    t_parse_state r_state, n_state, w_next_state;
    logic [15:0]  r_crc, n_crc;
    logic [7:0]   r_crc_hi, n_crc_hi;
    logic [7:0]   r_length, n_length;
    logic [7:0]   r_count, n_count;
    logic [7:0]   r_command, n_command;
    logic [7:0]   r_store [STORE_DEPTH];

    logic [15:0]  w_byte_crc;
    logic [15:0]  w_restart_crc;
    logic         w_is_a5;
    logic         w_crc_ok;
    logic         w_store_we;
    logic [7:0]   w_count_inc;

    assign w_is_a5       = (i_byte == HDR_FIRST);
    assign w_byte_crc    = crc16_update(r_crc, i_byte);
    assign w_restart_crc = w_is_a5 ? crc16_update(CRC_INIT, i_byte) : CRC_INIT;
    assign w_crc_ok      = ({r_crc_hi, i_byte} == r_crc);
    assign w_count_inc   = r_count + 8'd1;

    // next state
    always_comb begin
        w_next_state = r_state;
        unique case (r_state)
            ST_WAIT_A5: begin
                if (w_is_a5) w_next_state = ST_WAIT_5A;
            end
            ST_WAIT_5A: begin
                if (i_byte == HDR_SECOND) w_next_state = ST_LENGTH;
                else if (w_is_a5)         w_next_state = ST_WAIT_5A;
                else                      w_next_state = ST_WAIT_A5;
            end
            ST_LENGTH: begin
                w_next_state = ST_COMMAND;
            end
            ST_COMMAND: begin
                w_next_state = (r_length == 8'd0) ? ST_CRC_HI : ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                if (w_count_inc == r_length) w_next_state = ST_CRC_HI;
            end
            ST_CRC_HI: begin
                w_next_state = ST_CRC_LO;
            end
            ST_CRC_LO: begin
                if (w_crc_ok)     w_next_state = ST_TAIL;
                else if (w_is_a5) w_next_state = ST_WAIT_5A;
                else              w_next_state = ST_WAIT_A5;
            end
            ST_TAIL: begin
                if (i_byte == TAIL_BYTE) w_next_state = ST_WAIT_A5;
                else if (w_is_a5)        w_next_state = ST_WAIT_5A;
                else                     w_next_state = ST_WAIT_A5;
            end
        endcase
        n_state = i_step ? w_next_state : r_state;
    end

    // datapath updates
    always_comb begin
        n_crc      = r_crc;
        n_crc_hi   = r_crc_hi;
        n_length   = r_length;
        n_count    = r_count;
        n_command  = r_command;
        w_store_we = 1'b0;
        if (i_step) begin
            unique case (r_state)
                ST_WAIT_A5: begin
                    if (w_is_a5) n_crc = w_restart_crc;
                end
                ST_WAIT_5A: begin
                    n_crc = (i_byte == HDR_SECOND) ? w_byte_crc : w_restart_crc;
                end
                ST_LENGTH: begin
                    n_length = i_byte;
                    n_crc    = w_byte_crc;
                end
                ST_COMMAND: begin
                    n_command = i_byte;
                    n_crc     = w_byte_crc;
                    n_count   = 8'd0;
                end
                ST_PAYLOAD: begin
                    w_store_we = (r_count < 8'(STORE_DEPTH));
                    n_crc      = w_byte_crc;
                    n_count    = w_count_inc;
                end
                ST_CRC_HI: begin
                    n_crc_hi = i_byte;
                end
                ST_CRC_LO: begin
                    if (!w_crc_ok) n_crc = w_restart_crc;
                end
                ST_TAIL: begin
                    n_crc = (i_byte == TAIL_BYTE) ? CRC_INIT : w_restart_crc;
                end
            endcase
        end
    end

    // result formation
    always_comb begin
        o_emit                  = 1'b0;
        o_result                = '0;
        o_result.frame_command  = r_command;
        o_result.payload_length = r_length;
        o_result.frame_status   = FS_BAD_TAIL;
        unique case (r_state)
            ST_CRC_LO: begin
                o_emit                = !w_crc_ok;
                o_result.frame_status = FS_CRC_ERR;
            end
            ST_TAIL: begin
                o_emit = 1'b1;
                priority if (i_byte != TAIL_BYTE) begin
                    o_result.frame_status = FS_BAD_TAIL;
                end else if (r_command != i_decode_command) begin
                    o_result.frame_status = FS_OTHER_CMD;
                end else if (r_length < 8'(STORE_DEPTH)) begin
                    o_result.frame_status = FS_SHORT;
                end else begin
                    o_result.frame_status  = FS_DECODED;
                    o_result.speed_bits    = {r_store[3], r_store[2], r_store[1], r_store[0]};
                    o_result.yaw_bits      = {r_store[7], r_store[6], r_store[5], r_store[4]};
                    o_result.pitch_bits    = {r_store[11], r_store[10], r_store[9], r_store[8]};
                    o_result.roll_bits     = {r_store[15], r_store[14], r_store[13], r_store[12]};
                    o_result.distance_bits = {r_store[19], r_store[18], r_store[17], r_store[16]};
                    o_result.action_word   = {r_store[21], r_store[20]};
                end
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_WAIT_A5;
            r_crc     <= CRC_INIT;
            r_crc_hi  <= 8'd0;
            r_length  <= 8'd0;
            r_count   <= 8'd0;
            r_command <= 8'd0;
        end else begin
            r_state   <= n_state;
            r_crc     <= n_crc;
            r_crc_hi  <= n_crc_hi;
            r_length  <= n_length;
            r_count   <= n_count;
            r_command <= n_command;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_count[STORE_IDX_W-1:0]] <= i_byte;
        end
    end

endmodule

FILE: design/crc16_framed_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// crc16_framed_packet_receiver_core
// Hunts A5 5A framed packets in a byte stream, checks CRC-16/Modbus and the
// FF tail, and reports one status word per frame with the decoded fields.
// Throughput: one byte per cycle; a byte stalls only when a result is due
//   while both output slots are full.
// Path: input byte register, then parser, then a registered output slot.
// Reset: synchronous active low; parser back to header hunt, CRC to FFFF,
//   output slots emptied, decode command back to 02.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc16_framed_packet_receiver_core
    import crc16fpr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [7:0]   i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // frame_command, payload_length, speed_bits,
                                         // yaw_bits, pitch_bits, roll_bits,
                                         // distance_bits, action_word
    output logic [2:0]   m_axis_tuser    // frame_status
);

    logic [7:0] r_decode_command;
    logic       r_in_vld, n_in_vld;
    logic [7:0] r_in_byte;
    t_result    r_out, n_out;
    logic       r_out_vld, n_out_vld;
    t_result    r_skid, n_skid;
    logic       r_skid_vld, n_skid_vld;

    logic       w_emit;
    t_result    w_result;
    logic       w_step;
    logic       w_push;
    logic       w_pop;
    logic       w_accept;

    assign w_step        = r_in_vld && (!w_emit || !r_skid_vld);
    assign w_push        = w_step && w_emit;
    assign w_pop         = r_out_vld && m_axis_tready;
    assign s_axis_tready = !r_in_vld || w_step;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    crc16fpr_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_byte           (r_in_byte),
        .i_decode_command (r_decode_command),
        .o_emit           (w_emit),
        .o_result         (w_result)
    );

    always_comb begin
        n_in_vld = r_in_vld;
        if (w_accept)    n_in_vld = 1'b1;
        else if (w_step) n_in_vld = 1'b0;
    end

    // two-slot output buffer
    always_comb begin
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_skid     = r_skid;
        n_skid_vld = r_skid_vld;
        if (w_pop) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
        if (w_push) begin
            if (!n_out_vld) begin
                n_out     = w_result;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = w_result;
                n_skid_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_command <= DECODE_CMD_RST;
            r_in_vld         <= 1'b0;
            r_out_vld        <= 1'b0;
            r_skid_vld       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_decode_command <= i_cfg_wr_data;
            r_in_vld   <= n_in_vld;
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_in_byte <= s_axis_tdata;
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.frame_status;
    assign m_axis_tdata  = {r_out.action_word, r_out.distance_bits, r_out.roll_bits,
                            r_out.pitch_bits, r_out.yaw_bits, r_out.speed_bits,
                            r_out.payload_length, r_out.frame_command};

endmodule
